### rtl/sfls_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfls_pkg
// Shared types and constants of the straw leading/trailing edge selector.
// ----------------------------------------------------------------------------
package sfls_pkg;

  // defaults of the top-level parameters
  localparam int DEF_NUM_CHANNELS = 8192;
  localparam int DEF_TIME_BITS    = 21;

  // fixed port widths
  localparam int OP_W       = 2;
  localparam int CH_PORT_W  = 13;
  localparam int FIELD_W    = 20;
  localparam int DIFF_W     = FIELD_W + 1;
  localparam int DRIFT_W    = 21;
  localparam int WIDTH_W    = 22;
  localparam int CFG_ADDR_W = 2;

  // item operations
  typedef enum logic [OP_W-1:0] {
    OP_LEAD  = 2'd0,
    OP_TRAIL = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_LEAD_MIN  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_LEAD_MAX  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_TRAIL_MIN = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_TRAIL_MAX = 2'd3;

  // window reset values, 1/16 ns
  localparam logic signed [FIELD_W-1:0] LEAD_MIN_RST  = 20'sd0;
  localparam logic signed [FIELD_W-1:0] LEAD_MAX_RST  = 20'sd3040;
  localparam logic signed [FIELD_W-1:0] TRAIL_MIN_RST = 20'sd0;
  localparam logic signed [FIELD_W-1:0] TRAIL_MAX_RST = 20'sd4800;

  // accidental cut, d new and s stored leading time in 1/16 ns
  localparam int CUT_D_MIN   = 800;
  localparam int CUT_KA      = 1881;     // coefficient on s
  localparam int CUT_KB      = 1880;     // upper line slope on d
  localparam int CUT_CB      = 1109952;  // upper line offset
  localparam int CUT_KC      = 150;      // lower line slope on d
  localparam int CUT_CC      = 88560;    // lower line offset
  localparam int CUT_D_KNEE  = 3168;
  localparam int CUT_S_KNEE  = 1744;
  localparam int CUT_D_OFF   = 1424;
  localparam int CUT_KS      = 27;
  localparam int CUT_KD      = 94;
  localparam int CUT_SUM_MAX = 344880;

  // control sequence
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CALC,
    ST_WRITE
  } state_e;

endpackage

### rtl/straw_first_lead_last_trail_select_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// straw_first_lead_last_trail_select_top
// Per-channel drift-tube hit selector: earliest accepted leading edge, latest
// trailing edge, read-and-clear of one channel per read item.
// ----------------------------------------------------------------------------
// Each item is taken in while the block is idle, when its channel entry is
// also read from the channel memory; the corrected time and window tests are
// registered in the read step, the accidental-cut products in the calc step,
// and the entry is written back and the result registered in the write step,
// which waits while the held result is stalled. The block takes no new item
// before the last one is written back; a finished result sits in an output
// register, so the next item is taken while it waits. After reset the block
// clears the valid flags of all NUM_CHANNELS entries, one entry a cycle, and
// takes no item until the clear is done; configuration writes are taken at
// any time. Times are signed 1/16 ns; a corrected time is edge_time minus
// correction, saturated to TIME_BITS bits. Items flagged with a decode error,
// an unknown op or a channel number out of range change nothing and give a
// result with every field zero.
// ----------------------------------------------------------------------------
module straw_first_lead_last_trail_select_top #(
  parameter int NUM_CHANNELS = sfls_pkg::DEF_NUM_CHANNELS,
  parameter int TIME_BITS    = sfls_pkg::DEF_TIME_BITS
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  // configuration
  input  logic                                     cfg_we_i,
  input  logic [sfls_pkg::CFG_ADDR_W-1:0]          cfg_addr_i,
  input  logic [sfls_pkg::FIELD_W-1:0]             cfg_wdata_i,
  // input items
  input  logic                                     in_valid_i,
  output logic                                     in_stall_o,
  input  logic [sfls_pkg::OP_W-1:0]                op_i,
  input  logic [sfls_pkg::CH_PORT_W-1:0]           channel_i,
  input  logic signed [sfls_pkg::FIELD_W-1:0]      edge_time_i,
  input  logic signed [sfls_pkg::FIELD_W-1:0]      correction_i,
  input  logic                                     decode_error_i,
  // result items
  output logic                                     out_valid_o,
  input  logic                                     out_stall_i,
  output logic                                     accepted_o,
  output logic                                     has_leading_o,
  output logic                                     has_trailing_o,
  output logic signed [sfls_pkg::DRIFT_W-1:0]      drift_time_o,
  output logic signed [sfls_pkg::WIDTH_W-1:0]      time_width_o
);
  import sfls_pkg::*;

  // widths derived from the parameters
  localparam int CH_W  = $clog2(NUM_CHANNELS);
  localparam int ENT_W = 2 * TIME_BITS + 2;
  localparam int EW    = (TIME_BITS > DIFF_W) ? TIME_BITS : DIFF_W;
  localparam int PW    = TIME_BITS + 14;
  localparam int OW    = (TIME_BITS + 1 > WIDTH_W) ? TIME_BITS + 1 : WIDTH_W;

  localparam logic [CH_W-1:0] CLR_LAST = CH_W'(NUM_CHANNELS - 1);

  // saturation bounds of a stored time
  localparam logic signed [EW-1:0] T_HI = EW'((longint'(1) << (TIME_BITS - 1)) - 1);
  localparam logic signed [EW-1:0] T_LO = -T_HI - EW'(1);

  // cut constants at product width
  localparam logic signed [PW-1:0] K_A     = PW'(CUT_KA);
  localparam logic signed [PW-1:0] K_B     = PW'(CUT_KB);
  localparam logic signed [PW-1:0] C_B     = PW'(CUT_CB);
  localparam logic signed [PW-1:0] K_C     = PW'(CUT_KC);
  localparam logic signed [PW-1:0] C_C     = PW'(CUT_CC);
  localparam logic signed [PW-1:0] K_S     = PW'(CUT_KS);
  localparam logic signed [PW-1:0] K_D     = PW'(CUT_KD);
  localparam logic signed [PW-1:0] D_MIN   = PW'(CUT_D_MIN);
  localparam logic signed [PW-1:0] D_KNEE  = PW'(CUT_D_KNEE);
  localparam logic signed [PW-1:0] S_KNEE  = PW'(CUT_S_KNEE);
  localparam logic signed [PW-1:0] D_OFF   = PW'(CUT_D_OFF);
  localparam logic signed [PW-1:0] SUM_MAX = PW'(CUT_SUM_MAX);

  // control
  state_e state_q, state_d;
  logic [CH_W-1:0] clr_cnt_q;
  logic            in_accept;
  logic            clearing;
  logic            out_free;
  logic            wr_go;
  logic            mem_we;
  logic            entry_we;

  // window registers
  logic signed [FIELD_W-1:0] lead_min_q, lead_max_q, trail_min_q, trail_max_q;

  // item registers
  op_e                       op_q;
  logic [CH_W-1:0]           ch_q;
  logic                      ign_q;
  logic signed [FIELD_W-1:0] edge_q, corr_q;
  logic                      ch_out_of_range;
  logic                      op_unknown;

  // corrected time
  logic signed [DIFF_W-1:0]    diff;
  logic signed [EW-1:0]        diff_e;
  logic signed [EW-1:0]        t_sat;
  logic signed [TIME_BITS-1:0] t_q;
  logic                        lead_win_q, trail_win_q;

  // channel memory: {lead valid, lead time, trail valid, trail time}
  logic [ENT_W-1:0] mem_q [NUM_CHANNELS];
  logic [ENT_W-1:0] rd_q;
  logic [ENT_W-1:0] wr_data;
  logic [ENT_W-1:0] new_entry;
  logic [CH_W-1:0]  wr_addr;

  logic                        lead_v, trail_v;
  logic signed [TIME_BITS-1:0] lead_t, trail_t;

  // cut products
  logic signed [PW-1:0] dw_c, sw_c, dw, sw;
  logic signed [PW-1:0] pa_q, pb_q, pc_q, pd_q;
  logic                 cut_ok;

  // result
  logic                       hit;
  logic                       res_hl, res_ht;
  logic signed [OW-1:0]       width_wide;
  logic signed [DRIFT_W-1:0]  res_drift;
  logic signed [WIDTH_W-1:0]  res_width;
  logic                       out_valid_q;
  logic                       acc_q, hl_q, ht_q;
  logic signed [DRIFT_W-1:0]  drift_q;
  logic signed [WIDTH_W-1:0]  width_q;

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  assign in_accept = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_cnt_q == CLR_LAST) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_accept) state_d = ST_READ;
      end
      ST_READ:  state_d = ST_CALC;
      ST_CALC:  state_d = ST_WRITE;
      ST_WRITE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default:  state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    clearing   = 1'b0;
    wr_go      = 1'b0;
    case (state_q)
      ST_CLEAR: clearing = 1'b1;
      ST_IDLE:  in_stall_o = 1'b0;
      ST_WRITE: wr_go = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (clearing) clr_cnt_q <= clr_cnt_q + CH_W'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // configuration
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_min_q  <= LEAD_MIN_RST;
      lead_max_q  <= LEAD_MAX_RST;
      trail_min_q <= TRAIL_MIN_RST;
      trail_max_q <= TRAIL_MAX_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_LEAD_MIN:  lead_min_q  <= cfg_wdata_i;
        CFG_LEAD_MAX:  lead_max_q  <= cfg_wdata_i;
        CFG_TRAIL_MIN: trail_min_q <= cfg_wdata_i;
        CFG_TRAIL_MAX: trail_max_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // item capture: ignored items never write the memory
  // ---------------------------------------------------------------------------
  assign ch_out_of_range = 32'(channel_i) >= 32'(NUM_CHANNELS);
  assign op_unknown      = (op_i != OP_LEAD) && (op_i != OP_TRAIL) && (op_i != OP_READ);

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q   <= op_e'(op_i);
      ch_q   <= CH_W'(channel_i);
      ign_q  <= decode_error_i || op_unknown || ch_out_of_range;
      edge_q <= edge_time_i;
      corr_q <= correction_i;
    end
  end

  // corrected, saturated time and window tests, registered in the read step
  assign diff   = DIFF_W'(edge_q) - DIFF_W'(corr_q);
  assign diff_e = EW'(diff);

  always_comb begin
    if (diff_e > T_HI)      t_sat = T_HI;
    else if (diff_e < T_LO) t_sat = T_LO;
    else                    t_sat = diff_e;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_READ) begin
      t_q         <= t_sat[TIME_BITS-1:0];
      lead_win_q  <= (t_sat > EW'(lead_min_q)) && (t_sat < EW'(lead_max_q));
      trail_win_q <= (t_sat > EW'(trail_min_q)) && (t_sat < EW'(trail_max_q));
    end
  end

  // ---------------------------------------------------------------------------
  // channel memory, read at acceptance, written back in the last step
  // ---------------------------------------------------------------------------
  assign wr_addr = clearing ? clr_cnt_q : ch_q;
  assign wr_data = clearing ? '0 : new_entry;
  assign mem_we  = clearing || (wr_go && entry_we);

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[wr_addr] <= wr_data;
    if (in_accept) rd_q <= mem_q[CH_W'(channel_i)];
  end

  assign lead_v  = rd_q[ENT_W-1];
  assign lead_t  = rd_q[ENT_W-2 -: TIME_BITS];
  assign trail_v = rd_q[TIME_BITS];
  assign trail_t = rd_q[TIME_BITS-1:0];

  // ---------------------------------------------------------------------------
  // accidental cut: products registered, compares in the write step
  // ---------------------------------------------------------------------------
  assign dw_c = PW'(t_q);
  assign sw_c = PW'(lead_t);

  always_ff @(posedge clk_i) begin
    if (state_q == ST_CALC) begin
      pa_q <= sw_c * K_A;
      pb_q <= dw_c * K_B - C_B;
      pc_q <= dw_c * K_C - C_C;
      pd_q <= sw_c * K_S + dw_c * K_D;
    end
  end

  assign dw = dw_c;
  assign sw = sw_c;

  always_comb begin
    cut_ok = (dw > D_MIN) && (pa_q < pb_q) && (pa_q > pc_q);
    if ((dw > D_KNEE) && (sw > S_KNEE) && (sw < dw - D_OFF)) cut_ok = 1'b0;
    if ((dw > D_KNEE) && (sw <= S_KNEE) && (pd_q > SUM_MAX)) cut_ok = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // entry update and result
  // ---------------------------------------------------------------------------
  assign width_wide = OW'(trail_t) - OW'(lead_t);

  always_comb begin
    new_entry = rd_q;
    hit       = 1'b0;
    entry_we  = 1'b0;
    res_hl    = 1'b0;
    res_ht    = 1'b0;
    res_drift = '0;
    res_width = '0;
    if (!ign_q) begin
      case (op_q)
        OP_LEAD: begin
          if (lead_win_q) begin
            if (!lead_v || ((t_q < lead_t) && cut_ok)) begin
              hit = 1'b1;
              new_entry[ENT_W-1]              = 1'b1;
              new_entry[ENT_W-2 -: TIME_BITS] = t_q;
            end
          end
          entry_we = hit;
        end
        OP_TRAIL: begin
          if (trail_win_q && (!trail_v || (t_q > trail_t))) begin
            hit = 1'b1;
            new_entry[TIME_BITS]       = 1'b1;
            new_entry[TIME_BITS-1:0]   = t_q;
          end
          entry_we = hit;
        end
        OP_READ: begin
          // reports the channel and clears both flags
          entry_we               = 1'b1;
          new_entry[ENT_W-1]     = 1'b0;
          new_entry[TIME_BITS]   = 1'b0;
          if (lead_v) begin
            res_hl    = 1'b1;
            res_drift = DRIFT_W'(lead_t);
            if (trail_v) begin
              res_ht    = 1'b1;
              res_width = width_wide[WIDTH_W-1:0];
            end
          end
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (wr_go) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_go) begin
      acc_q   <= hit;
      hl_q    <= res_hl;
      ht_q    <= res_ht;
      drift_q <= res_drift;
      width_q <= res_width;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign accepted_o     = acc_q;
  assign has_leading_o  = hl_q;
  assign has_trailing_o = ht_q;
  assign drift_time_o   = drift_q;
  assign time_width_o   = width_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_seq_read_calc : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |=> (state_q == ST_CALC))
    else $error("read step not followed by product step");

  a_result_from_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_WRITE))
    else $error("result appeared outside the write step");

  a_mem_write_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> ((state_q == ST_WRITE) || (state_q == ST_CLEAR)))
    else $error("channel memory written outside write or clear");

  a_trail_needs_lead : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && has_trailing_o) |-> has_leading_o)
    else $error("trailing reported without leading");

  a_edge_or_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(accepted_o && has_leading_o))
    else $error("edge and read result mixed");

endmodule
